// ----- hw/rtl/lkvc_pkg.sv -----
// Package with the shared types and codes of the LRU key-value cache.
package lkvc_pkg;

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  localparam int CAP_BITS = 5;
  localparam int OCC_BITS = 5;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_VALRD,
    ST_RESULT
  } state_t;

endpackage

// ----- hw/rtl/lkvc_if.sv -----
// Request and response channel interfaces of the LRU key-value cache.
interface lkvc_req_if #(
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic                  cmd;
  logic [KEY_BITS-1:0]   lookup_key;
  logic [VALUE_BITS-1:0] write_value;
  logic                  touch;

  modport source (output valid, cmd, lookup_key, write_value, touch, input ready);
  modport sink   (input valid, cmd, lookup_key, write_value, touch, output ready);
endinterface

interface lkvc_rsp_if #(
  parameter int VALUE_BITS = 32
);
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [VALUE_BITS-1:0] read_value;
  logic [4:0]            occupancy;

  modport source (output valid, hit, read_value, occupancy, input ready);
  modport sink   (input valid, hit, read_value, occupancy, output ready);
endinterface

// ----- hw/rtl/lru_key_value_cache_core.sv -----
// Top level of the fully associative LRU key-value cache.
//
//   channel  role    transfer when        payload
//   req      sink    req.valid&req.ready  cmd, lookup_key, write_value, touch
//   rsp      source  rsp.valid&rsp.ready  hit, read_value, occupancy
//   cfg      write   cfg_we               cfg_wdata (capacity_limit)
//
// An item runs scan, decide, result; a get hit adds a value read before result.
// The key RAM is scanned one entry per cycle through its single read port.
// Reset clears the valid bits, the ranks, the entry count and sets the capacity to 16.
// The result is held in an output register while the sink stalls.
module lru_key_value_cache_core
  import lkvc_pkg::*;
#(
  parameter int ENTRIES    = 16,
  parameter int KEY_BITS   = 32,
  parameter int VALUE_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  lkvc_req_if.sink            req,
  lkvc_rsp_if.source          rsp,
  input  logic                cfg_we,
  input  logic [CAP_BITS-1:0] cfg_wdata
);

  localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW   = $clog2(ENTRIES + 1);
  localparam int CAPW = (CW > CAP_BITS) ? CW : CAP_BITS;

  state_t state, state_next;

  logic [CAP_BITS-1:0]   cap_lim;
  logic [CW-1:0]         count;
  logic [ENTRIES-1:0]    valid;
  logic [IW-1:0]         rank [ENTRIES];
  logic [IW-1:0]         rank_next [ENTRIES];
  logic [ENTRIES-1:0]    valid_next;
  logic [CW-1:0]         count_next;

  logic                  cmd_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;
  logic                  touch_q;
  logic [CW-1:0]         sc;
  logic                  found_q;
  logic [IW-1:0]         found_slot;
  logic                  free_q;
  logic [IW-1:0]         free_slot;
  logic [IW-1:0]         lru_slot;

  logic                  ov;
  logic                  hit_o;
  logic [VALUE_BITS-1:0] rd_o;
  logic [OCC_BITS-1:0]   occ_o;
  logic [VALUE_BITS-1:0] rd_q;

  logic [KEY_BITS-1:0]   key_rdata;
  logic [VALUE_BITS-1:0] val_rdata;
  logic                  key_we;
  logic                  val_we;
  logic [IW-1:0]         sel_slot;
  logic [IW-1:0]         prev_idx;
  logic [CAPW-1:0]       lim_x;
  logic [CAPW-1:0]       cap_eff;
  logic                  evict;
  logic                  do_promote;
  logic                  do_insert;
  logic                  load_out;

  lkvc_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (sel_slot),
    .wdata (key_q),
    .raddr (sc[IW-1:0]),
    .rdata (key_rdata)
  );

  lkvc_ram #(.WIDTH(VALUE_BITS), .DEPTH(ENTRIES)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (sel_slot),
    .wdata (val_q),
    .raddr (found_slot),
    .rdata (val_rdata)
  );

  assign prev_idx = IW'(sc - CW'(1));
  assign lim_x    = CAPW'(cap_lim);
  assign cap_eff  = (lim_x == '0) ? CAPW'(1) :
                    ((lim_x > CAPW'(ENTRIES)) ? CAPW'(ENTRIES) : lim_x);
  assign evict    = CAPW'(count) >= cap_eff;
  assign sel_slot = found_q ? found_slot : (evict ? lru_slot : free_slot);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    key_we     = 1'b0;
    val_we     = 1'b0;
    do_promote = 1'b0;
    do_insert  = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sc == CW'(ENTRIES)) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (cmd_q == CMD_GET) begin
          do_promote = found_q && touch_q;
          state_next = found_q ? ST_VALRD : ST_RESULT;
        end else begin
          val_we     = 1'b1;
          key_we     = !found_q;
          do_promote = found_q || evict;
          do_insert  = !found_q && !evict;
          state_next = ST_RESULT;
        end
      end
      ST_VALRD: begin
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (!ov || rsp.ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    valid_next = valid;
    count_next = count;
    for (int i = 0; i < ENTRIES; i++) begin
      rank_next[i] = rank[i];
      if (do_promote) begin
        if (IW'(i) == sel_slot) begin
          rank_next[i] = '0;
        end else if (valid[i] && rank[i] < rank[sel_slot]) begin
          rank_next[i] = rank[i] + IW'(1);
        end
      end else if (do_insert) begin
        if (IW'(i) == sel_slot) begin
          rank_next[i]  = '0;
          valid_next[i] = 1'b1;
        end else if (valid[i]) begin
          rank_next[i] = rank[i] + IW'(1);
        end
      end
    end
    if (do_insert) begin
      count_next = count + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_lim <= CAP_RESET;
      count   <= '0;
      valid   <= '0;
      ov      <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        cap_lim <= cfg_wdata;
      end
      count <= count_next;
      valid <= valid_next;
      for (int i = 0; i < ENTRIES; i++) begin
        rank[i] <= rank_next[i];
      end
      if (load_out) begin
        ov <= 1'b1;
      end else if (rsp.ready) begin
        ov <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req.valid) begin
      cmd_q   <= req.cmd;
      key_q   <= req.lookup_key;
      val_q   <= req.write_value;
      touch_q <= req.touch;
      sc      <= '0;
      found_q <= 1'b0;
      free_q  <= 1'b0;
    end
    if (state == ST_SCAN) begin
      sc <= sc + CW'(1);
      if (sc != '0) begin
        if (valid[prev_idx] && key_rdata == key_q && !found_q) begin
          found_q    <= 1'b1;
          found_slot <= prev_idx;
        end
        if (!valid[prev_idx] && !free_q) begin
          free_q    <= 1'b1;
          free_slot <= prev_idx;
        end
        if (valid[prev_idx] && rank[prev_idx] == IW'(count - CW'(1))) begin
          lru_slot <= prev_idx;
        end
      end
    end
    if (state == ST_DECIDE) begin
      rd_q <= '0;
    end
    if (state == ST_VALRD) begin
      rd_q <= val_rdata;
    end
    if (load_out) begin
      hit_o <= found_q;
      rd_o  <= rd_q;
      occ_o <= OCC_BITS'(count);
    end
  end

  assign rsp.valid      = ov;
  assign rsp.hit        = hit_o;
  assign rsp.read_value = rd_o;
  assign rsp.occupancy  = occ_o;

endmodule

// ----- hw/rtl/lkvc_ram.sv -----
// Generic single write port RAM with one registered read port.
module lkvc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
